// File: rtl/cbb_pkg.sv
// cbb_pkg: shared types and constants for the cubic bezier bounds accumulator
// no dependencies; imported by every rtl module of the block
package cbb_pkg;

  localparam int COORD_W = 32;
  // raw coefficient width before scaling
  localparam int COEF_W  = COORD_W + 3;
  // scaled coefficient magnitudes stay below 2^SC_W
  localparam int SC_W    = 30;
  localparam int MUL_W   = (COORD_W + 1 > SC_W) ? COORD_W + 1 : SC_W;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int DIV_W   = SC_W + 1;
  localparam int CNT_W   = $clog2(ROOT_W);

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_POINT = 2'd1;
  localparam logic [1:0] REQ_CUBIC = 2'd2;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic signed [COORD_W-1:0]  p0_x;
    logic signed [COORD_W-1:0]  p0_y;
    logic signed [COORD_W-1:0]  p1_x;
    logic signed [COORD_W-1:0]  p1_y;
    logic signed [COORD_W-1:0]  p2_x;
    logic signed [COORD_W-1:0]  p2_y;
    logic signed [COORD_W-1:0]  p3_x;
    logic signed [COORD_W-1:0]  p3_y;
  } cbb_req_t;

  typedef struct packed {
    logic                       box_valid;
    logic signed [COORD_W-1:0]  box_left;
    logic signed [COORD_W-1:0]  box_top;
    logic signed [COORD_W-1:0]  box_right;
    logic signed [COORD_W-1:0]  box_bottom;
  } cbb_box_t;

  typedef struct packed {
    logic start;
    logic is_sqrt;
  } cbb_unit_cmd_t;

endpackage

// File: rtl/cbb_mul.sv
// cbb_mul: shared unsigned multiplier with registered product
// depends on cbb_pkg
module cbb_mul (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [cbb_pkg::MUL_W-1:0]       a_i,
  input  logic [cbb_pkg::MUL_W-1:0]       b_i,
  output logic [2*cbb_pkg::MUL_W-1:0]     p_o
);
  import cbb_pkg::*;

  logic [2*MUL_W-1:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
    end else begin
      p_q <= (2*MUL_W)'(a_i) * (2*MUL_W)'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

// File: rtl/cbb_isqdiv.sv
// cbb_isqdiv: iterative unit, one bit per cycle, doing either integer square root
// or fractional division num/den with num < den; depends on cbb_pkg
module cbb_isqdiv #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cbb_pkg::cbb_unit_cmd_t        cmd_i,
  input  logic [cbb_pkg::RAD_W-1:0]     rad_i,
  input  logic [cbb_pkg::DIV_W-1:0]     num_i,
  input  logic [cbb_pkg::DIV_W-1:0]     den_i,
  output logic                          done_o,
  output logic [cbb_pkg::ROOT_W-1:0]    res_o
);
  import cbb_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic              busy_q, sqrt_q, done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] acc_q;
  logic [RAD_W-1:0]  rad_q;
  logic [DIV_W-1:0]  den_q;

  logic [REM_W-1:0]  rem_sh, trial;
  logic              fits;

  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
      trial  = {acc_q, 2'b01};
    end else begin
      rem_sh = {rem_q[REM_W-2:0], 1'b0};
      trial  = REM_W'(den_q);
    end
    fits = (rem_sh >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sqrt_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      acc_q  <= '0;
      rad_q  <= '0;
      den_q  <= '0;
    end else begin
      done_q <= !cmd_i.start && busy_q && (cnt_q == '0);
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        sqrt_q <= cmd_i.is_sqrt;
        cnt_q  <= cmd_i.is_sqrt ? CNT_W'(ROOT_W - 1) : CNT_W'(T_FRAC_BITS - 1);
        rem_q  <= cmd_i.is_sqrt ? '0 : REM_W'(num_i);
        acc_q  <= '0;
        rad_q  <= rad_i;
        den_q  <= den_i;
      end else if (busy_q) begin
        rem_q <= fits ? rem_sh - trial : rem_sh;
        acc_q <= {acc_q[ROOT_W-2:0], fits};
        rad_q <= rad_q << 2;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

// File: rtl/cubic_bezier_bounds_accumulator_unit.sv
// cubic_bezier_bounds_accumulator_unit: top level, sequencer and box registers
// depends on cbb_pkg, cbb_mul, cbb_isqdiv
//
//  channel | dir | handshake              | beat
//  in      | in  | in_valid_i / in_stall_o  | cbb_req_t: request code and p0..p3
//  out     | out | out_valid_o / out_stall_i| cbb_box_t: box after the request
//
// clear, point and unused codes go from accept through S_DONE to the result beat.
// a cubic adds p0 and p3, then works through both axes; each axis may use the
// 32-step square root and up to two bit-serial root divides in cbb_isqdiv.
// one request at a time; the result register lets the next beat in while a
// result waits, a stalled output holds the next result at its final step.
// reset empties the box, no clearing pass.
module cubic_bezier_bounds_accumulator_unit #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  cbb_pkg::cbb_req_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output cbb_pkg::cbb_box_t  out_data_o
);
  import cbb_pkg::*;

  localparam int CW = COORD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_ADD3, S_COEF, S_SCALE, S_MBB, S_MAC, S_DISC, S_SQRT,
    S_TRY, S_DIV, S_MIX_A, S_MIX_B, S_TRY_END, S_NEXT_AXIS, S_DONE
  } state_e;

  function automatic logic [COEF_W-1:0] coef_mag(input logic signed [COEF_W-1:0] v);
    return v[COEF_W-1] ? COEF_W'(-v) : COEF_W'(v);
  endfunction

  state_e state_q;
  cbb_req_t req_q;
  logic have_q;
  logic signed [CW-1:0] minx_q, miny_q, maxx_q, maxy_q;
  logic out_valid_q;
  cbb_box_t out_q;
  logic ax_q;
  logic [COEF_W-1:0] am_q, bm_q, cm_q;
  logic sa_q, sb_q, sc_q;
  logic [RAD_W-1:0] bb_q;
  logic [DIV_W-1:0] m_q, num_q, den_q;
  logic qneg_q, two_q, nneg_q, dneg_q;
  logic [T_FRAC_BITS-1:0] t_q;
  logic signed [CW-1:0] w0_q, w1_q, w2_q, w3_q, rx_q;
  logic [2:0] step_q;
  logic eax_q, mneg_q;

  // shared units
  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  cbb_unit_cmd_t unit_cmd;
  logic [RAD_W-1:0] disc;
  logic unit_done;
  logic [ROOT_W-1:0] unit_res;

  cbb_mul u_mul (
    .clk_i (clk_i), .rst_ni (rst_ni), .a_i (mul_a), .b_i (mul_b), .p_o (mul_p)
  );

  cbb_isqdiv #(.T_FRAC_BITS(T_FRAC_BITS)) u_isqdiv (
    .clk_i (clk_i), .rst_ni (rst_ni), .cmd_i (unit_cmd), .rad_i (disc),
    .num_i (num_q), .den_i (den_q), .done_o (unit_done), .res_o (unit_res)
  );

  // coefficients of the derivative on the current axis
  logic signed [CW-1:0] v0, v1, v2, v3;
  logic signed [COEF_W-1:0] ve0, ve1, ve2, ve3, d12, ca, cb, cc;
  logic [SC_W-1:0] am_s, bm_s, cm_s;
  logic big, all_zero, bneg;

  assign v0 = ax_q ? req_q.p0_y : req_q.p0_x;
  assign v1 = ax_q ? req_q.p1_y : req_q.p1_x;
  assign v2 = ax_q ? req_q.p2_y : req_q.p2_x;
  assign v3 = ax_q ? req_q.p3_y : req_q.p3_x;
  assign ve0 = COEF_W'(v0);
  assign ve1 = COEF_W'(v1);
  assign ve2 = COEF_W'(v2);
  assign ve3 = COEF_W'(v3);
  assign d12 = ve1 - ve2;
  assign ca  = ve3 - ve0 + d12 + (d12 <<< 1);
  assign cb  = (ve0 - (ve1 <<< 1) + ve2) <<< 1;
  assign cc  = ve1 - ve0;

  assign am_s = am_q[SC_W-1:0];
  assign bm_s = bm_q[SC_W-1:0];
  assign cm_s = cm_q[SC_W-1:0];
  assign big  = (|am_q[COEF_W-1:SC_W]) | (|bm_q[COEF_W-1:SC_W]) | (|cm_q[COEF_W-1:SC_W]);
  assign all_zero = (am_q == '0) && (bm_q == '0) && (cm_q == '0);
  assign bneg = sb_q && (bm_s != '0);

  // discriminant from b^2 and a*c
  logic [RAD_W-1:0] ac4, disc_sum;
  logic [RAD_W:0] disc_diff;
  logic acneg, disc_neg;

  assign ac4       = {mul_p[RAD_W-3:0], 2'b00};
  assign acneg     = sa_q ^ sc_q;
  assign disc_sum  = bb_q + ac4;
  assign disc_diff = {1'b0, bb_q} - {1'b0, ac4};
  assign disc      = acneg ? disc_sum : disc_diff[RAD_W-1:0];
  assign disc_neg  = !acneg && disc_diff[RAD_W];

  // q magnitude: (|b| + root) / 2
  logic [ROOT_W:0] msum;
  logic [DIV_W-1:0] m_next;
  assign msum   = {1'b0, unit_res} + (ROOT_W+1)'(bm_s);
  assign m_next = msum[DIV_W:1];

  logic try_ok;
  assign try_ok = (den_q != '0) && (num_q != '0) && (nneg_q == dneg_q) && (num_q < den_q);

  // de casteljau step operands
  logic signed [CW-1:0] mp, mq, mix_res;
  logic [CW:0] dmix, udmix, prod, resw;

  always_comb begin
    unique case (step_q)
      3'd1, 3'd4: begin mp = w1_q; mq = w2_q; end
      3'd2:       begin mp = w2_q; mq = w3_q; end
      default:    begin mp = w0_q; mq = w1_q; end
    endcase
  end

  assign dmix  = {mq[CW-1], mq} - {mp[CW-1], mp};
  assign udmix = dmix[CW] ? (~dmix + 1'b1) : dmix;
  assign prod  = mul_p[T_FRAC_BITS +: CW+1];
  assign resw  = mneg_q ? ({mp[CW-1], mp} - prod) : ({mp[CW-1], mp} + prod);
  assign mix_res = resw[CW-1:0];

  always_comb begin
    unique case (state_q)
      S_MBB:   begin mul_a = MUL_W'(bm_s);  mul_b = MUL_W'(bm_s); end
      S_MAC:   begin mul_a = MUL_W'(am_s);  mul_b = MUL_W'(cm_s); end
      S_MIX_A: begin mul_a = MUL_W'(udmix); mul_b = MUL_W'(t_q);  end
      default: begin mul_a = '0;            mul_b = '0;           end
    endcase
  end

  always_comb begin
    unit_cmd.start   = 1'b0;
    unit_cmd.is_sqrt = 1'b0;
    if (state_q == S_DISC && !disc_neg) begin
      unit_cmd.start   = 1'b1;
      unit_cmd.is_sqrt = 1'b1;
    end else if (state_q == S_TRY && try_ok) begin
      unit_cmd.start   = 1'b1;
    end
  end

  // point insertion into the box
  logic pt_add, box_clr;
  logic signed [CW-1:0] ptx, pty;

  always_comb begin
    pt_add  = 1'b0;
    box_clr = 1'b0;
    ptx     = in_data_i.p0_x;
    pty     = in_data_i.p0_y;
    if (state_q == S_IDLE && in_valid_i) begin
      box_clr = (in_data_i.req_type == REQ_CLEAR);
      pt_add  = (in_data_i.req_type == REQ_POINT) || (in_data_i.req_type == REQ_CUBIC);
    end else if (state_q == S_ADD3) begin
      pt_add = 1'b1;
      ptx    = req_q.p3_x;
      pty    = req_q.p3_y;
    end else if (state_q == S_MIX_B && step_q == 3'd5 && eax_q) begin
      pt_add = 1'b1;
      ptx    = rx_q;
      pty    = mix_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      minx_q <= '0;
      miny_q <= '0;
      maxx_q <= '0;
      maxy_q <= '0;
    end else if (box_clr) begin
      have_q <= 1'b0;
      minx_q <= '0;
      miny_q <= '0;
      maxx_q <= '0;
      maxy_q <= '0;
    end else if (pt_add) begin
      have_q <= 1'b1;
      if (!have_q) begin
        minx_q <= ptx;
        maxx_q <= ptx;
        miny_q <= pty;
        maxy_q <= pty;
      end else begin
        if (ptx < minx_q) minx_q <= ptx;
        if (ptx > maxx_q) maxx_q <= ptx;
        if (pty < miny_q) miny_q <= pty;
        if (pty > maxy_q) maxy_q <= pty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
      ax_q        <= 1'b0;
      am_q        <= '0;
      bm_q        <= '0;
      cm_q        <= '0;
      sa_q        <= 1'b0;
      sb_q        <= 1'b0;
      sc_q        <= 1'b0;
      bb_q        <= '0;
      m_q         <= '0;
      num_q       <= '0;
      den_q       <= '0;
      qneg_q      <= 1'b0;
      two_q       <= 1'b0;
      nneg_q      <= 1'b0;
      dneg_q      <= 1'b0;
      t_q         <= '0;
      w0_q        <= '0;
      w1_q        <= '0;
      w2_q        <= '0;
      w3_q        <= '0;
      rx_q        <= '0;
      step_q      <= '0;
      eax_q       <= 1'b0;
      mneg_q      <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_data_i;
            state_q <= (in_data_i.req_type == REQ_CUBIC) ? S_ADD3 : S_DONE;
          end
        end
        S_ADD3: begin
          ax_q    <= 1'b0;
          state_q <= S_COEF;
        end
        S_COEF: begin
          am_q    <= coef_mag(ca);
          bm_q    <= coef_mag(cb);
          cm_q    <= coef_mag(cc);
          sa_q    <= ca[COEF_W-1];
          sb_q    <= cb[COEF_W-1];
          sc_q    <= cc[COEF_W-1];
          state_q <= S_SCALE;
        end
        S_SCALE: begin
          if (all_zero) begin
            state_q <= S_NEXT_AXIS;
          end else if (big) begin
            am_q <= am_q >> 1;
            bm_q <= bm_q >> 1;
            cm_q <= cm_q >> 1;
          end else if (am_s == '0) begin
            if (bm_s == '0) begin
              state_q <= S_NEXT_AXIS;
            end else begin
              // linear case: root -c/b
              num_q   <= DIV_W'(cm_s);
              nneg_q  <= !sc_q;
              den_q   <= DIV_W'(bm_s);
              dneg_q  <= sb_q;
              two_q   <= 1'b0;
              state_q <= S_TRY;
            end
          end else begin
            state_q <= S_MBB;
          end
        end
        S_MBB: state_q <= S_MAC;
        S_MAC: begin
          bb_q    <= mul_p[RAD_W-1:0];
          state_q <= S_DISC;
        end
        S_DISC: state_q <= disc_neg ? S_NEXT_AXIS : S_SQRT;
        S_SQRT: begin
          if (unit_done) begin
            m_q    <= m_next;
            qneg_q <= !bneg;
            if (m_next == '0) begin
              // double root -b/(2a)
              num_q  <= DIV_W'(bm_s);
              nneg_q <= !sb_q;
              den_q  <= {am_s, 1'b0};
              dneg_q <= sa_q;
              two_q  <= 1'b0;
            end else begin
              num_q  <= m_next;
              nneg_q <= !bneg;
              den_q  <= DIV_W'(am_s);
              dneg_q <= sa_q;
              two_q  <= 1'b1;
            end
            state_q <= S_TRY;
          end
        end
        S_TRY: state_q <= try_ok ? S_DIV : S_TRY_END;
        S_DIV: begin
          if (unit_done) begin
            if (unit_res[T_FRAC_BITS-1:0] == '0) begin
              state_q <= S_TRY_END;
            end else begin
              t_q     <= unit_res[T_FRAC_BITS-1:0];
              w0_q    <= req_q.p0_x;
              w1_q    <= req_q.p1_x;
              w2_q    <= req_q.p2_x;
              w3_q    <= req_q.p3_x;
              step_q  <= '0;
              eax_q   <= 1'b0;
              state_q <= S_MIX_A;
            end
          end
        end
        S_MIX_A: begin
          mneg_q  <= dmix[CW];
          state_q <= S_MIX_B;
        end
        S_MIX_B: begin
          if (step_q == 3'd5) begin
            if (!eax_q) begin
              rx_q    <= mix_res;
              w0_q    <= req_q.p0_y;
              w1_q    <= req_q.p1_y;
              w2_q    <= req_q.p2_y;
              w3_q    <= req_q.p3_y;
              step_q  <= '0;
              eax_q   <= 1'b1;
              state_q <= S_MIX_A;
            end else begin
              state_q <= S_TRY_END;
            end
          end else begin
            unique case (step_q)
              3'd1, 3'd4: w1_q <= mix_res;
              3'd2:       w2_q <= mix_res;
              default:    w0_q <= mix_res;
            endcase
            step_q  <= step_q + 1'b1;
            state_q <= S_MIX_A;
          end
        end
        S_TRY_END: begin
          if (two_q) begin
            // second root c/q
            two_q   <= 1'b0;
            num_q   <= DIV_W'(cm_s);
            nneg_q  <= sc_q;
            den_q   <= m_q;
            dneg_q  <= qneg_q;
            state_q <= S_TRY;
          end else begin
            state_q <= S_NEXT_AXIS;
          end
        end
        S_NEXT_AXIS: begin
          if (!ax_q) begin
            ax_q    <= 1'b1;
            state_q <= S_COEF;
          end else begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q      <= 1'b1;
            out_q.box_valid  <= have_q;
            out_q.box_left   <= minx_q;
            out_q.box_top    <= miny_q;
            out_q.box_right  <= maxx_q;
            out_q.box_bottom <= maxy_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// testbench for cubic_bezier_bounds_accumulator_unit: directed and random requests
// depends on cbb_pkg and the rtl; its own box predictor checks every result beat
module testbench;
  import cbb_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam longint unsigned T_ONE = 64'd1 << 16;
  localparam longint unsigned COEF_LIMIT = 64'd1 << 30;
  localparam int CYCLE_LIMIT = 2000000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  cbb_req_t in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cbb_box_t out_data;

  cbb_box_t box_q[$];
  int       errors = 0;
  int       cycles = 0;
  bit       quiet = 1'b0;
  bit       hold_req = 1'b0;
  bit       in_gaps = 1'b1;

  // predicted box state
  bit       have_box;
  longint   min_x, min_y, max_x, max_y;

  cubic_bezier_bounds_accumulator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic longint unsigned mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint blend(longint p, longint q, longint unsigned t);
    longint d;
    longint unsigned ud, prod;
    d = q - p;
    ud = mag(d);
    prod = (ud >> 16) * t + (((ud & (T_ONE - 1)) * t) >> 16);
    return d < 0 ? p - longint'(prod) : p + longint'(prod);
  endfunction

  function automatic longint curve_at(longint v[4], longint unsigned t);
    longint m01, m12, m23;
    m01 = blend(v[0], v[1], t);
    m12 = blend(v[1], v[2], t);
    m23 = blend(v[2], v[3], t);
    return blend(blend(m01, m12, t), blend(m12, m23, t), t);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint shrink(longint v, int s);
    longint unsigned m;
    m = mag(v) >> s;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  task automatic widen(longint x, longint y);
    if (!have_box) begin
      have_box = 1'b1;
      min_x = x; max_x = x; min_y = y; max_y = y;
    end else begin
      if (x < min_x) min_x = x;
      if (x > max_x) max_x = x;
      if (y < min_y) min_y = y;
      if (y > max_y) max_y = y;
    end
  endtask

  task automatic trial_root(longint num, longint den, longint xs[4], longint ys[4]);
    longint unsigned t;
    if (den == 0) return;
    if (num != 0 && ((num < 0) != (den < 0))) return;
    t = (mag(num) << 16) / mag(den);
    if (t == 0 || t >= T_ONE) return;
    widen(curve_at(xs, t), curve_at(ys, t));
  endtask

  task automatic axis_turns(longint v[4], longint xs[4], longint ys[4]);
    longint a, b, c, d, q;
    longint unsigned mx, rt, m;
    int s;
    a = -v[0] + 3 * v[1] - 3 * v[2] + v[3];
    b = 2 * (v[0] - 2 * v[1] + v[2]);
    c = v[1] - v[0];
    s = 0;
    mx = mag(a);
    if (mag(b) > mx) mx = mag(b);
    if (mag(c) > mx) mx = mag(c);
    if (mx == 0) return;
    while ((mx >> s) >= COEF_LIMIT) s++;
    a = shrink(a, s);
    b = shrink(b, s);
    c = shrink(c, s);
    if (a == 0) begin
      if (b != 0) trial_root(-c, b, xs, ys);
      return;
    end
    d = b * b - 4 * a * c;
    if (d < 0) return;
    rt = int_sqrt(d);
    m = (mag(b) + rt) >> 1;
    q = b < 0 ? longint'(m) : -longint'(m);
    if (q == 0) begin
      trial_root(-b, 2 * a, xs, ys);
    end else begin
      trial_root(q, a, xs, ys);
      trial_root(c, q, xs, ys);
    end
  endtask

  task automatic predict_box(cbb_req_t r);
    longint xs[4], ys[4];
    cbb_box_t b;
    xs = '{r.p0_x, r.p1_x, r.p2_x, r.p3_x};
    ys = '{r.p0_y, r.p1_y, r.p2_y, r.p3_y};
    case (r.req_type)
      REQ_CLEAR: begin
        have_box = 1'b0;
        min_x = 0; min_y = 0; max_x = 0; max_y = 0;
      end
      REQ_POINT: widen(xs[0], ys[0]);
      REQ_CUBIC: begin
        widen(xs[0], ys[0]);
        widen(xs[3], ys[3]);
        axis_turns(xs, xs, ys);
        axis_turns(ys, xs, ys);
      end
      default: ;
    endcase
    b.box_valid  = have_box;
    b.box_left   = have_box ? min_x[31:0] : '0;
    b.box_top    = have_box ? min_y[31:0] : '0;
    b.box_right  = have_box ? max_x[31:0] : '0;
    b.box_bottom = have_box ? max_y[31:0] : '0;
    box_q.push_back(b);
  endtask

  // one request beat; valid stays high unless a gap follows
  task automatic send_req(cbb_req_t r);
    in_data  <= r;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    predict_box(r);
    if (in_gaps && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (box_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      cbb_box_t e;
      if (box_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = box_q.pop_front();
        if (out_data.box_valid !== e.box_valid) begin
          $error("box_valid exp %0d got %0d", e.box_valid, out_data.box_valid); errors++;
        end
        if (out_data.box_left !== e.box_left) begin
          $error("box_left exp %0d got %0d", e.box_left, out_data.box_left); errors++;
        end
        if (out_data.box_top !== e.box_top) begin
          $error("box_top exp %0d got %0d", e.box_top, out_data.box_top); errors++;
        end
        if (out_data.box_right !== e.box_right) begin
          $error("box_right exp %0d got %0d", e.box_right, out_data.box_right); errors++;
        end
        if (out_data.box_bottom !== e.box_bottom) begin
          $error("box_bottom exp %0d got %0d", e.box_bottom, out_data.box_bottom); errors++;
        end
      end
    end
  end

  // receiver stalls in bursts, or one long hold on request
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (2000) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_req = 1'b0;
        @(posedge clk_i);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
        out_stall <= 1'b0;
        @(posedge clk_i);
      end else begin
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $signed($urandom_range(0, 2 ** 21)) - 32'sd1048576;
      2: return $signed($urandom_range(0, 2000)) - 32'sd1000;
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic cbb_req_t rand_req(logic [1:0] kind);
    cbb_req_t r;
    r.req_type = kind;
    r.p0_x = rand_coord(); r.p0_y = rand_coord();
    r.p1_x = rand_coord(); r.p1_y = rand_coord();
    r.p2_x = rand_coord(); r.p2_y = rand_coord();
    r.p3_x = rand_coord(); r.p3_y = rand_coord();
    return r;
  endfunction

  function automatic cbb_req_t cubic(longint x0, x1, x2, x3, y0, y1, y2, y3);
    cbb_req_t r;
    r.req_type = REQ_CUBIC;
    r.p0_x = 32'(x0); r.p1_x = 32'(x1); r.p2_x = 32'(x2); r.p3_x = 32'(x3);
    r.p0_y = 32'(y0); r.p1_y = 32'(y1); r.p2_y = 32'(y2); r.p3_y = 32'(y3);
    return r;
  endfunction

  task automatic test_directed();
    cbb_req_t r;
    r = '0;
    send_req(r);                               // clear on an empty box
    r.req_type = REQ_POINT;
    send_req(r);
    r.p0_x = 32'h7fff_ffff; r.p0_y = 32'h8000_0000;
    send_req(r);
    r.p0_x = 32'h8000_0000; r.p0_y = 32'h7fff_ffff;
    send_req(r);
    r.req_type = REQ_UNUSED; r.p0_x = 5; r.p0_y = 5;
    send_req(r);                               // unused code reports the box
    r.req_type = REQ_CLEAR;
    send_req(r);
    r.req_type = REQ_UNUSED;
    send_req(r);
    send_req(cubic(7, 7, 7, 7, -3, -3, -3, -3));     // flat on both axes
    send_req(cubic(0, 10, 20, 30, 0, 65536, 65536, 0)); // linear x, parabola y
    send_req(cubic(0, 5, 5, 90, 9, 9, 9, 100));      // double root at the start
    send_req(cubic(0, 100000, -100000, 0, 0, 3, 1, 4));
    send_req(cubic(0, 1, 2, 3, 0, 50, 51, 10));      // no real turn on x
    send_req(cubic(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
                   32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000));
    send_req(cubic(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                   0, 32'sh7fff_ffff, 32'sh7fff_ffff, 0));
    r.req_type = REQ_CLEAR;
    send_req(r);
    send_req(cubic(-65536, 65536, -65536, 65536, 1, -1, 1, -1));
    send_req(rand_req(REQ_CUBIC));
  endtask

  // receiver holds off while requests keep coming, then a full pause
  task automatic test_backpressure();
    in_gaps = 1'b0;
    hold_req = 1'b1;
    repeat (6) send_req(rand_req(REQ_CUBIC));
    repeat (6) send_req(rand_req(REQ_POINT));
    in_gaps = 1'b1;
    drain();
  endtask

  task automatic test_random(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      if (k == 0) send_req(rand_req(REQ_CLEAR));
      else if (k == 1) send_req(rand_req(REQ_UNUSED));
      else if (k < 7) send_req(rand_req(REQ_POINT));
      else send_req(rand_req(REQ_CUBIC));
    end
  endtask

  initial begin
    have_box = 1'b0;
    min_x = 0; min_y = 0; max_x = 0; max_y = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(480);
    quiet = 1'b1;
    test_random(100);
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0 && box_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
